### sv/sad_pkg.sv
// Shared constants, types and codes of the step amplitude detector.
package sad_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int MAX_COUNT    = 4095;

   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 12;
   localparam int THRESH_W   = 17;
   localparam int PEAK_W     = 19;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // per-lane history: seven previous samples, window taps at ages 2, 3, 5, 6
   localparam int HIST_DEPTH = 7;
   localparam int DIFF_W     = SAMPLE_W + 2;
   localparam int TOTAL_W    = DIFF_W + $clog2(NUM_CHANNELS);
   localparam int METRIC_W   = TOTAL_W - 1;
   localparam int LIMIT_W    = THRESH_W + 3;
   localparam int WIDE_W     = ((METRIC_W > LIMIT_W) ? METRIC_W : LIMIT_W) + 1;

   localparam logic [COUNT_W-1:0]  FIRST_COMMIT   = COUNT_W'(9);
   localparam logic [COUNT_W-1:0]  COUNT_MAX      = COUNT_W'(MAX_COUNT);
   localparam logic [COUNT_W-1:0]  MIN_LEN_RESET  = COUNT_W'(50);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = LIMIT_W'(6 * 400);
   localparam logic [WIDE_W-1:0]   PEAK_MAX_WIDE  = WIDE_W'((1 << PEAK_W) - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_MIN_LENGTH = 2'd1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PASS  = 2'd0,
      STATUS_LOW   = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

   // control travelling alongside the lane data through the pipeline
   typedef struct packed {
      logic valid;
      logic commit;
      logic eoe;
      logic too_short;
   } ctrl_type;

endpackage

### sv/sad_req_if.sv
// Request channel: four channel samples and the end-of-event mark.
interface sad_req_if;
   logic                         valid;
   logic                         ready;
   logic [sad_pkg::SAMPLE_W-1:0] sample_ch0;
   logic [sad_pkg::SAMPLE_W-1:0] sample_ch1;
   logic [sad_pkg::SAMPLE_W-1:0] sample_ch2;
   logic [sad_pkg::SAMPLE_W-1:0] sample_ch3;
   logic                         end_of_event;

   modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   end_of_event, input ready);
   modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   end_of_event, output ready);
endinterface

### sv/sad_rsp_if.sv
// Result channel: scaled peak amplitude and event status.
interface sad_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sad_pkg::PEAK_W-1:0]   peak_amplitude_x6;
   logic [sad_pkg::STATUS_W-1:0] event_status;

   modport source (output valid, peak_amplitude_x6, event_status, input ready);
   modport sink   (input valid, peak_amplitude_x6, event_status, output ready);
endinterface

### sv/sad_lane.sv
// One channel lane: sample history and its share of the smoothed difference.
module sad_lane (
   input  logic                                clock,
   input  logic                                shift_en,
   input  logic [sad_pkg::SAMPLE_W-1:0]        sample,
   output logic signed [sad_pkg::DIFF_W-1:0]   diff_ff
);

   logic [sad_pkg::SAMPLE_W-1:0]      hist_ff [sad_pkg::HIST_DEPTH];
   logic signed [sad_pkg::DIFF_W-1:0] pos;
   logic signed [sad_pkg::DIFF_W-1:0] neg;
   logic signed [sad_pkg::DIFF_W-1:0] diff_in;

   // taps by age before the shift: t-3, t-4 against t-6, t-7
   always_comb begin
      pos     = $signed(sad_pkg::DIFF_W'(hist_ff[2])) + $signed(sad_pkg::DIFF_W'(hist_ff[3]));
      neg     = $signed(sad_pkg::DIFF_W'(hist_ff[5])) + $signed(sad_pkg::DIFF_W'(hist_ff[6]));
      diff_in = pos - neg;
   end

   // history needs no reset: committed windows only reach samples of the event
   always_ff @(posedge clock) begin
      if (shift_en) begin
         hist_ff[0] <= sample;
         for (int k = 1; k < sad_pkg::HIST_DEPTH; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
         diff_ff <= diff_in;
      end
   end

endmodule

### sv/sad_merge.sv
// Merge of the lane differences, running peak and result register.
module sad_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_ready,
   output logic                                advance,
   input  sad_pkg::ctrl_type                   ctrl0,
   input  logic signed [sad_pkg::DIFF_W-1:0]   lane_diff [sad_pkg::NUM_CHANNELS],
   input  logic [sad_pkg::LIMIT_W-1:0]         limit,
   output logic                                rsp_valid_ff,
   output logic [sad_pkg::PEAK_W-1:0]          rsp_peak_ff,
   output logic [sad_pkg::STATUS_W-1:0]        rsp_status_ff
);

   sad_pkg::ctrl_type                  ctrl1_ff;
   logic [sad_pkg::METRIC_W-1:0]       metric_ff;
   logic [sad_pkg::METRIC_W-1:0]       metric_in;
   logic signed [sad_pkg::TOTAL_W-1:0] total;
   logic [sad_pkg::TOTAL_W-1:0]        magnitude;
   logic [sad_pkg::METRIC_W-1:0]       peak_ff;
   logic [sad_pkg::METRIC_W-1:0]       peak_in;
   logic [sad_pkg::METRIC_W-1:0]       candidate;
   logic [sad_pkg::WIDE_W-1:0]         peak_wide;
   logic [sad_pkg::PEAK_W-1:0]         peak_out;
   logic                               result_due;
   sad_pkg::status_type                status;

   // stall only when a new result meets one still waiting in the result register
   assign result_due = ctrl1_ff.valid && ctrl1_ff.eoe;
   assign advance    = !(result_due && rsp_valid_ff && !rsp_ready);

   // stage 1: adder tree over the lanes, magnitude
   always_comb begin
      total = '0;
      for (int k = 0; k < sad_pkg::NUM_CHANNELS; k++) begin
         total = total + sad_pkg::TOTAL_W'(lane_diff[k]);
      end
      magnitude = (total < 0) ? sad_pkg::TOTAL_W'(-total) : sad_pkg::TOTAL_W'(total);
      metric_in = magnitude[sad_pkg::METRIC_W-1:0];
   end

   // stage 2: peak update and result
   always_comb begin
      candidate = ctrl1_ff.commit ? metric_ff : '0;
      peak_in   = (candidate > peak_ff) ? candidate : peak_ff;
      peak_wide = sad_pkg::WIDE_W'(peak_in);
      peak_out  = (peak_wide > sad_pkg::PEAK_MAX_WIDE) ? sad_pkg::PEAK_W'(sad_pkg::PEAK_MAX_WIDE)
                                                       : sad_pkg::PEAK_W'(peak_wide);
      if (ctrl1_ff.too_short) begin
         status = sad_pkg::STATUS_SHORT;
      end else if (peak_wide < sad_pkg::WIDE_W'(limit)) begin
         status = sad_pkg::STATUS_LOW;
      end else begin
         status = sad_pkg::STATUS_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            ctrl1_ff <= ctrl0;
            if (ctrl1_ff.valid) begin
               peak_ff <= ctrl1_ff.eoe ? '0 : peak_in;
            end
         end
         if (advance && result_due) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         metric_ff <= metric_in;
         if (result_due) begin
            rsp_peak_ff   <= ctrl1_ff.too_short ? '0 : peak_out;
            rsp_status_ff <= status;
         end
      end
   end

endmodule

### sv/step_amplitude_detector.sv
// Step amplitude detector top level: event length count, registers, lanes and merge.
//
// Accepts one request per clock, each carrying one sample of four channels. Four
// lanes keep each channel's history and form its part of the smoothed central
// difference; a merge stage adds the lanes, takes the magnitude and keeps
// the event's running peak. When the request with the end-of-event mark has gone
// through the three-stage pipeline, one result gives the peak scaled by six and the
// status (passed, below threshold, too short). The last request passes the lane and
// merge registers before its result is written. The pipeline holds only when a
// finished result reaches the result register while the previous one is still
// waiting to be taken; otherwise a request is accepted every cycle. Registers are
// written by index: 0 threshold, 1 minimum event length; other indexes are ignored.
module step_amplitude_detector (
   input  logic                             clock,
   input  logic                             reset,
   sad_req_if.sink                          req_ch,
   sad_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [sad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sad_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                                advance;
   logic                                accept;
   logic [sad_pkg::COUNT_W-1:0]         index_ff;
   logic [sad_pkg::COUNT_W-1:0]         index_in;
   logic [sad_pkg::COUNT_W-1:0]         count;
   logic [sad_pkg::COUNT_W-1:0]         min_len_ff;
   logic [sad_pkg::LIMIT_W-1:0]         limit_ff;
   logic [sad_pkg::LIMIT_W-1:0]         thresh_ext;
   sad_pkg::ctrl_type                   ctrl0_ff;
   sad_pkg::ctrl_type                   ctrl0_in;
   logic [sad_pkg::SAMPLE_W-1:0]        sample [sad_pkg::NUM_CHANNELS];
   logic signed [sad_pkg::DIFF_W-1:0]   lane_diff [sad_pkg::NUM_CHANNELS];
   logic                                rsp_valid;
   logic [sad_pkg::PEAK_W-1:0]          rsp_peak;
   logic [sad_pkg::STATUS_W-1:0]        rsp_status;

   assign accept       = req_ch.valid && advance;
   assign req_ch.ready = advance;

   assign sample[0] = req_ch.sample_ch0;
   assign sample[1] = req_ch.sample_ch1;
   assign sample[2] = req_ch.sample_ch2;
   assign sample[3] = req_ch.sample_ch3;

   // threshold held as six times its value
   assign thresh_ext = sad_pkg::LIMIT_W'(csr_wdata[sad_pkg::THRESH_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= sad_pkg::LIMIT_RESET;
         min_len_ff <= sad_pkg::MIN_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sad_pkg::CSR_THRESHOLD:  limit_ff   <= (thresh_ext << 2) + (thresh_ext << 1);
            sad_pkg::CSR_MIN_LENGTH: min_len_ff <= csr_wdata[sad_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      count = (index_ff < sad_pkg::COUNT_MAX) ? index_ff + 1'b1 : sad_pkg::COUNT_MAX;
      index_in = req_ch.end_of_event ? '0 : count;
      ctrl0_in.valid     = accept;
      ctrl0_in.commit    = index_ff >= sad_pkg::FIRST_COMMIT;
      ctrl0_in.eoe       = req_ch.end_of_event;
      ctrl0_in.too_short = count < min_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         ctrl0_ff <= '0;
      end else begin
         if (accept) begin
            index_ff <= index_in;
         end
         if (advance) begin
            ctrl0_ff <= ctrl0_in;
         end
      end
   end

   for (genvar g = 0; g < sad_pkg::NUM_CHANNELS; g++) begin : g_lane
      sad_lane u_lane (
         .clock    (clock),
         .shift_en (accept),
         .sample   (sample[g]),
         .diff_ff  (lane_diff[g])
      );
   end

   sad_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .rsp_ready     (rsp_ch.ready),
      .advance       (advance),
      .ctrl0         (ctrl0_ff),
      .lane_diff     (lane_diff),
      .limit         (limit_ff),
      .rsp_valid_ff  (rsp_valid),
      .rsp_peak_ff   (rsp_peak),
      .rsp_status_ff (rsp_status)
   );

   assign rsp_ch.valid             = rsp_valid;
   assign rsp_ch.peak_amplitude_x6 = rsp_peak;
   assign rsp_ch.event_status      = rsp_status;

endmodule

### tb/tb_step_amplitude_detector.sv
// Self-checking testbench of the step amplitude detector: directed table, then random events.
`timescale 1ns / 1ps

module tb_step_amplitude_detector;

   localparam int SAMPLE_W      = sad_pkg::SAMPLE_W;
   localparam int PEAK_W        = sad_pkg::PEAK_W;
   localparam int COUNT_W       = sad_pkg::COUNT_W;
   localparam int THRESH_W      = sad_pkg::THRESH_W;
   localparam int LIMIT_W       = sad_pkg::LIMIT_W;
   localparam int CSR_IDX_W     = sad_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W    = sad_pkg::CSR_DATA_W;
   localparam int SUM_W         = SAMPLE_W + $clog2(sad_pkg::NUM_CHANNELS);
   localparam int PEAK_RUN_W    = SUM_W + 2;
   localparam int SMOOTH_SCALE  = 6;
   localparam int THRESH_RESET  = 400;
   localparam int THRESH_TOP    = 87380;
   localparam int FULL_STEP_X6  = 2 * sad_pkg::NUM_CHANNELS * 65535;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_REQS    = 200;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SRC_IDLE [4]   = '{0, 56, 0, 27};
   localparam int SINK_STALL [4] = '{0, 0, 56, 27};

   localparam logic [PEAK_RUN_W-1:0] PEAK_CAP    = PEAK_RUN_W'((1 << PEAK_W) - 1);
   localparam logic [SAMPLE_W-1:0]   FULL_SCALE  = '1;
   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] ch0;
      logic [SAMPLE_W-1:0] ch1;
      logic [SAMPLE_W-1:0] ch2;
      logic [SAMPLE_W-1:0] ch3;
      logic                eoe;
   } sample_set_type;

   typedef struct packed {
      logic [PEAK_W-1:0]   peak;
      sad_pkg::status_type status;
   } event_result_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef enum {STYLE_NOISE, STYLE_RAIL, STYLE_STEP} wave_style_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      sample_set_type        samples;
      bit                    check;
      event_result_type      want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sad_req_if req_ch();
   sad_rsp_if rsp_ch();

   step_amplitude_detector uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [SUM_W-1:0]      sum_hist [8];
   logic [COUNT_W-1:0]    evt_len;
   logic [PEAK_RUN_W-1:0] peak_run;
   logic [THRESH_W-1:0]   thr_reg;
   logic [COUNT_W-1:0]    min_len_reg;

   event_result_type pending_results [$];

   int err_count      = 0;
   int req_count      = 0;
   int rsp_count      = 0;
   int csr_count      = 0;
   int cycle_count    = 0;
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;

   function automatic void clear_event_state();
      for (int k = 0; k < 8; k++) sum_hist[k] = '0;
      evt_len  = '0;
      peak_run = '0;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         sad_pkg::CSR_THRESHOLD:  thr_reg = val[THRESH_W-1:0];
         sad_pkg::CSR_MIN_LENGTH: min_len_reg = val[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   // Advances the predicted state by one request; returns 1 when it closes an event.
   function automatic bit predict_sample(sample_set_type s, output event_result_type res);
      logic [SUM_W-1:0]   total;
      logic [SUM_W:0]     pos;
      logic [SUM_W:0]     neg;
      logic [SUM_W:0]     metric;
      logic [COUNT_W-1:0] len_now;
      logic [LIMIT_W-1:0] limit;
      total = SUM_W'(s.ch0) + SUM_W'(s.ch1) + SUM_W'(s.ch2) + SUM_W'(s.ch3);
      for (int k = 7; k > 0; k--) sum_hist[k] = sum_hist[k-1];
      sum_hist[0] = total;
      if (evt_len >= sad_pkg::FIRST_COMMIT) begin
         pos    = sum_hist[3] + sum_hist[4];
         neg    = sum_hist[6] + sum_hist[7];
         metric = (pos >= neg) ? pos - neg : neg - pos;
         if (PEAK_RUN_W'(metric) > peak_run) peak_run = PEAK_RUN_W'(metric);
      end
      len_now = (evt_len < sad_pkg::COUNT_MAX) ? evt_len + 1'b1 : sad_pkg::COUNT_MAX;
      evt_len = len_now;
      res.peak   = '0;
      res.status = sad_pkg::STATUS_SHORT;
      if (!s.eoe) return 1'b0;
      if (len_now >= min_len_reg) begin
         limit      = LIMIT_W'(thr_reg) * LIMIT_W'(SMOOTH_SCALE);
         res.peak   = PEAK_W'((peak_run > PEAK_CAP) ? PEAK_CAP : peak_run);
         res.status = (peak_run < limit) ? sad_pkg::STATUS_LOW : sad_pkg::STATUS_PASS;
      end
      clear_event_state();
      return 1'b1;
   endfunction

   function automatic dir_row_type req_row(logic [SAMPLE_W-1:0] v0, logic [SAMPLE_W-1:0] v1,
                                           logic [SAMPLE_W-1:0] v2, logic [SAMPLE_W-1:0] v3,
                                           logic eoe, bit check, logic [PEAK_W-1:0] peak,
                                           sad_pkg::status_type st);
      dir_row_type row;
      row.kind        = ROW_REQ;
      row.csr_idx     = '0;
      row.csr_val     = '0;
      row.samples     = {v0, v1, v2, v3, eoe};
      row.check       = check;
      row.want.peak   = peak;
      row.want.status = st;
      return row;
   endfunction

   function automatic dir_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] val);
      dir_row_type row;
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      row.samples = '0;
      row.check   = 1'b0;
      row.want    = '0;
      return row;
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample(wave_style_type style, int level);
      case (style)
         STYLE_NOISE: return SAMPLE_W'($urandom_range(65535));
         STYLE_RAIL:  return $urandom_range(1) ? FULL_SCALE : '0;
         default:     return SAMPLE_W'(level + $urandom_range(63));
      endcase
   endfunction

   // All driving tasks start and end at a falling edge.
   task automatic send_request(input sample_set_type s, input bit typed,
                               input event_result_type want);
      event_result_type got;
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.sample_ch0   <= s.ch0;
      req_ch.sample_ch1   <= s.ch1;
      req_ch.sample_ch2   <= s.ch2;
      req_ch.sample_ch3   <= s.ch3;
      req_ch.end_of_event <= s.eoe;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_count++;
      if (predict_sample(s, got)) begin
         pending_results.insert(pending_results.size(), typed ? want : got);
      end
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // a request without a result may still be in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_csr(idx, val);
      csr_count++;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_event(input int len, input wave_style_type style);
      sample_set_type s;
      int base;
      int height;
      int step_at;
      int level;
      base    = $urandom_range(40000);
      height  = $urandom_range(1) ? $urandom_range(25000) : $urandom_range(200);
      step_at = $urandom_range(len - 1);
      for (int k = 0; k < len; k++) begin
         level = (k >= step_at) ? base + height : base;
         s.ch0 = draw_sample(style, level);
         s.ch1 = draw_sample(style, level);
         s.ch2 = draw_sample(style, level);
         s.ch3 = draw_sample(style, level);
         s.eoe = (k == len - 1);
         send_request(s, 1'b0, '0);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      event_result_type head;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: peak_amplitude_x6 %0d, event_status %0d",
                   rsp_ch.peak_amplitude_x6, rsp_ch.event_status);
            err_count++;
         end else begin
            head = pending_results.pop_front();
            if (rsp_ch.peak_amplitude_x6 !== head.peak) begin
               $error("peak_amplitude_x6: expected %0d, actual %0d",
                      head.peak, rsp_ch.peak_amplitude_x6);
               err_count++;
            end
            if (rsp_ch.event_status !== head.status) begin
               $error("event_status: expected %0d, actual %0d", head.status, rsp_ch.event_status);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      dir_row_type         rows [$];
      logic [SAMPLE_W-1:0] lvl;
      wave_style_type      style;
      int                  r;
      int                  thr;
      int                  mlen;
      int                  len;
      int                  phase_reqs;
      int                  phase_rsps;
      int                  n_events;

      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.sample_ch0   = '0;
      req_ch.sample_ch1   = '0;
      req_ch.sample_ch2   = '0;
      req_ch.sample_ch3   = '0;
      req_ch.end_of_event = 1'b0;
      thr_reg             = THRESH_W'(THRESH_RESET);
      min_len_reg         = sad_pkg::MIN_LEN_RESET;
      clear_event_state();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset values, no-window events, ignored indexes, full-scale steps
      rows.insert(rows.size(), req_row('0, '0, '0, '0, 1'b1, 1'b1, '0,
                                       sad_pkg::STATUS_SHORT));
      rows.insert(rows.size(), req_row(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1,
                                       1'b1, '0, sad_pkg::STATUS_SHORT));
      rows.insert(rows.size(), csr_row(sad_pkg::CSR_MIN_LENGTH, CSR_DATA_W'(1)));
      rows.insert(rows.size(), csr_row(sad_pkg::CSR_THRESHOLD, '0));
      rows.insert(rows.size(), req_row(16'd1, 16'd2, 16'd3, 16'd4, 1'b1, 1'b1, '0,
                                       sad_pkg::STATUS_PASS));
      rows.insert(rows.size(), csr_row(sad_pkg::CSR_THRESHOLD, CSR_DATA_W'(1)));
      rows.insert(rows.size(), csr_row(CSR_SPARE_2, '0));
      rows.insert(rows.size(), csr_row(CSR_SPARE_3, '1));
      rows.insert(rows.size(), req_row(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1,
                                       1'b1, '0, sad_pkg::STATUS_LOW));
      // upper bits dropped: 10
      rows.insert(rows.size(), csr_row(sad_pkg::CSR_MIN_LENGTH, 17'h1F00A));
      rows.insert(rows.size(), csr_row(sad_pkg::CSR_THRESHOLD, CSR_DATA_W'(THRESH_TOP)));
      for (int k = 0; k < 10; k++) begin
         lvl = (k < 5) ? '0 : FULL_SCALE;
         rows.insert(rows.size(), req_row(lvl, lvl, lvl, lvl, k == 9, k == 9,
                                          PEAK_W'(FULL_STEP_X6), sad_pkg::STATUS_PASS));
      end
      for (int k = 0; k < 10; k++) begin
         lvl = (k < 5) ? FULL_SCALE : '0;
         rows.insert(rows.size(), req_row(lvl, lvl, lvl, lvl, k == 9, k == 9,
                                          PEAK_W'(FULL_STEP_X6), sad_pkg::STATUS_PASS));
      end

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            wait_quiet();
            write_csr(rows[i].csr_idx, rows[i].csr_val);
         end else begin
            send_request(rows[i].samples, rows[i].check, rows[i].want);
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         wait_quiet();
         src_idle_pct   = SRC_IDLE[ph];
         sink_stall_pct = SINK_STALL[ph];
         phase_reqs     = req_count;
         phase_rsps     = rsp_count;
         n_events       = 0;
         while (req_count - phase_reqs < PHASE_REQS || rsp_count - phase_rsps < 12) begin
            if (n_events % 6 == 0) begin
               wait_quiet();
               r   = $urandom_range(3);
               thr = (r == 0) ? 0 : (r == 1) ? THRESH_TOP :
                     (r == 2) ? $urandom_range(THRESH_TOP) : $urandom_range(3000);
               write_csr(sad_pkg::CSR_THRESHOLD, CSR_DATA_W'(thr));
               r    = $urandom_range(7);
               mlen = (r == 0) ? 10 : (r == 1) ? sad_pkg::MAX_COUNT : $urandom_range(10, 28);
               write_csr(sad_pkg::CSR_MIN_LENGTH,
                         {(CSR_DATA_W - COUNT_W)'($urandom), COUNT_W'(mlen)});
               if ($urandom_range(3) == 0) begin
                  write_csr($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3,
                            CSR_DATA_W'($urandom));
               end
            end
            len   = ($urandom_range(9) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 32);
            r     = $urandom_range(9);
            style = (r < 2) ? STYLE_NOISE : (r < 3) ? STYLE_RAIL : STYLE_STEP;
            send_event(len, style);
            n_events++;
            if ($urandom_range(7) == 0) wait_quiet();
         end
      end

      wait_quiet();
      $display("Covered %0d requests, %0d results and %0d register writes over four idle mixes,",
               req_count, rsp_count, csr_count);
      $display("with corner rows, windowless and short events, full-scale steps and spare indexes.");
      if (err_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
